// ----- hw/rtl/box_average_downsampler_defines.svh -----
// Assertion macros shared by the box average downsampler RTL.
// Included by the modules that carry concurrent assertions; needs no package.
`ifndef BOX_AVERAGE_DOWNSAMPLER_DEFINES_SVH
`define BOX_AVERAGE_DOWNSAMPLER_DEFINES_SVH

// Checked on every rising edge except while reset is high.
`define BOXDS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BOXDS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/boxds_pkg.sv -----
// Package of the box average downsampler: field widths, register indexes and
// the item types passed between its modules. Depends on nothing.
package boxds_pkg;

   localparam int PIX_W        = 16;
   localparam int FACTOR_W     = 5;
   localparam int SIZE_W       = 13;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int ROW_W        = $clog2(HEIGHT_LIMIT);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SIZE_W;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_FACTOR = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_IN_WIDTH     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_IN_HEIGHT    = CSR_IDX_W'(2);

   typedef struct packed {
      logic row_done;
      logic frame_done;
   } boxds_mark_type;

   typedef struct packed {
      logic [PIX_W-1:0] average_value;
      logic             row_done;
      logic             frame_done;
   } boxds_rsp_type;

endpackage

// ----- hw/rtl/boxds_if.sv -----
// Handshake channels of the box average downsampler: pixel input, result
// output and register writes. Depends on boxds_pkg.
interface boxds_pix_if
   import boxds_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink (input valid, input pixel_value, output ready);
endinterface

interface boxds_avg_if
   import boxds_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] average_value;
   logic             row_done;
   logic             frame_done;

   modport source (output valid, output average_value, output row_done,
                   output frame_done, input ready);
   modport sink (input valid, input average_value, input row_done,
                 input frame_done, output ready);
endinterface

interface boxds_csr_if
   import boxds_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/boxds_divide.sv -----
// Three-stage pipeline that turns a block sum into its floor average by a
// reciprocal multiply and one correction step. Depends on boxds_pkg.
`include "box_average_downsampler_defines.svh"

module boxds_divide
   import boxds_pkg::*;
#(
   parameter int TOT_W = 24,
   parameter int RCP_W = 25,
   parameter int DIV_W = 9
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           in_valid,
   input  logic [TOT_W-1:0] in_total,
   input  boxds_mark_type in_mark,
   input  logic [RCP_W-1:0] recip,
   input  logic [DIV_W-1:0] divisor,
   output logic           out_valid,
   output boxds_rsp_type  out_rsp
);

   localparam int PRD_W = TOT_W + RCP_W;
   localparam int QD_W  = TOT_W + DIV_W;

   logic             s2_valid_ff;
   logic [TOT_W-1:0] s2_total_ff;
   boxds_mark_type   s2_mark_ff;

   logic             s3_valid_ff;
   logic [TOT_W-1:0] s3_total_ff;
   logic [TOT_W-1:0] s3_q_ff;
   boxds_mark_type   s3_mark_ff;

   logic             s4_valid_ff;
   logic [TOT_W-1:0] s4_total_ff;
   logic [TOT_W-1:0] s4_q_ff;
   logic [TOT_W-1:0] s4_qd_ff;
   boxds_mark_type   s4_mark_ff;

   logic [PRD_W-1:0] prod;
   logic [QD_W-1:0]  qd_full;
   logic [TOT_W-1:0] rem;
   logic [TOT_W-1:0] q_fix;

   assign prod    = PRD_W'(s2_total_ff) * PRD_W'(recip);
   assign qd_full = QD_W'(s3_q_ff) * QD_W'(divisor);
   assign rem     = s4_total_ff - s4_qd_ff;
   assign q_fix   = (rem >= TOT_W'(divisor)) ? s4_q_ff + TOT_W'(1) : s4_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= in_valid;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_total_ff <= in_total;
         s2_mark_ff  <= in_mark;
         s3_total_ff <= s2_total_ff;
         s3_q_ff     <= prod[TOT_W +: TOT_W];
         s3_mark_ff  <= s2_mark_ff;
         s4_total_ff <= s3_total_ff;
         s4_q_ff     <= s3_q_ff;
         s4_qd_ff    <= qd_full[TOT_W-1:0];
         s4_mark_ff  <= s3_mark_ff;
      end
   end

   assign out_valid              = s4_valid_ff;
   assign out_rsp.average_value  = q_fix[PIX_W-1:0];
   assign out_rsp.row_done       = s4_mark_ff.row_done;
   assign out_rsp.frame_done     = s4_mark_ff.frame_done;

   `BOXDS_ASSERT(a_est_not_above, clock, reset,
      s4_valid_ff |-> s4_qd_ff <= s4_total_ff, "quotient estimate too large")
   `BOXDS_ASSERT(a_one_correction, clock, reset,
      s4_valid_ff |-> (TOT_W+1)'(rem) < ((TOT_W+1)'(divisor) << 1),
      "quotient estimate off by more than one")
   `BOXDS_ASSERT(a_hold_on_stall, clock, reset,
      s4_valid_ff && !advance |=> s4_valid_ff && $stable(s4_q_ff),
      "last division stage changed while stalled")

endmodule

// ----- hw/rtl/box_average_downsampler.sv -----
// Box average downsampler top level: counters, column sum memory, and the
// result register. Depends on boxds_pkg, boxds_if and boxds_divide.
//
// Pixels of one frame enter on req_ch in raster order, one item per cycle while req_ch.ready is high.
// Each block_factor x block_factor block is summed; when its bottom-right
// pixel is taken, one item leaves on rsp_ch with the floor average and the
// end-of-row and end-of-frame marks. Pixels outside whole blocks produce
// nothing. Partial block sums per output column live in a synchronous RAM of
// WIDTH_LIMIT words with one read and one write port; an entry is read when a
// pixel is taken and written back when that pixel leaves the first stage.
// The result passes the first stage, the divider stages and the result register;
// while rsp_ch does not stall and csr_ch offers no write, the block sustains one pixel per clock.
// csr_ch writes block_factor (0), in_width (1) and in_height (2); such a write restarts the
// frame. The user must make a write only while no item is in flight; the block does not enforce it.
// Reset restores factor 1 and a 4096 x 4096 frame; the RAM is not cleared.
// When rsp_ch stalls, the pipeline keeps taking pixels until a finished
// result waits in both the output register and the last divider stage.
`include "box_average_downsampler_defines.svh"

module box_average_downsampler
   import boxds_pkg::*;
#(
   parameter int WIDTH_LIMIT = 4096,
   parameter int MAX_FACTOR  = 16
) (
   input logic         clock,
   input logic         reset,
   boxds_pix_if.sink   req_ch,
   boxds_avg_if.source rsp_ch,
   boxds_csr_if.sink   csr_ch
);

   localparam int COL_W = $clog2(WIDTH_LIMIT);
   localparam int WID_W = $clog2(WIDTH_LIMIT + 1);
   localparam int EXT_W = WID_W + 1;
   localparam int FAC_W = $clog2(MAX_FACTOR + 1);
   localparam int PH_W  = $clog2(MAX_FACTOR);
   localparam int HGT_W = ROW_W + 1;
   localparam int RX_W  = ROW_W + 2;
   localparam int RS_W  = PIX_W + $clog2(MAX_FACTOR);
   localparam int TOT_W = PIX_W + 2 * $clog2(MAX_FACTOR);
   localparam int RCP_W = TOT_W + 1;
   localparam int DIV_W = $clog2(MAX_FACTOR * MAX_FACTOR + 1);

   logic [FACTOR_W-1:0] factor_ff;
   logic [SIZE_W-1:0]   width_ff;
   logic [SIZE_W-1:0]   height_ff;

   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_blk_ff;
   logic [COL_W-1:0] oc_ff;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_blk_ff;
   logic [PH_W-1:0]  cphase_ff;
   logic [PH_W-1:0]  rphase_ff;
   logic [RS_W-1:0]  row_sum_ff;

   logic [FAC_W-1:0] f_eff;
   logic [WID_W-1:0] w_eff;
   logic [HGT_W-1:0] h_eff;

   logic             req_acc;
   logic             csr_acc;
   logic             csr_hit;
   logic             advance;
   logic             col_ok;
   logic             row_ok;
   logic             in_blk;
   logic             c_wrap;
   logic             r_wrap;
   logic             col_last;
   logic             row_last;
   boxds_mark_type   mark_now;
   logic [RS_W-1:0]  sum_now;

   logic             s1_valid_ff;
   logic             s1_first_ff;
   logic             s1_last_ff;
   logic [RS_W-1:0]  s1_sum_ff;
   logic [COL_W-1:0] s1_addr_ff;
   boxds_mark_type   s1_mark_ff;
   logic [TOT_W-1:0] s1_total;
   logic             mem_we;

   logic [TOT_W-1:0] col_mem [WIDTH_LIMIT];
   logic [TOT_W-1:0] mem_rd_ff;

   logic [RCP_W-1:0] recip_tbl [MAX_FACTOR + 1];
   logic [RCP_W-1:0] recip_ff;
   logic [DIV_W-1:0] divisor_ff;

   logic             div_valid;
   boxds_rsp_type    div_rsp;
   logic             rsp_valid_ff;
   boxds_rsp_type    rsp_data_ff;

   for (genvar g = 0; g <= MAX_FACTOR; g++) begin : g_recip
      localparam longint unsigned DIVISOR = (g == 0) ? 1 : g * g;
      localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << TOT_W) / DIVISOR);
      assign recip_tbl[g] = RECIP;
   end

   always_comb begin
      if (factor_ff == '0) begin
         f_eff = FAC_W'(1);
      end else if (32'(factor_ff) > MAX_FACTOR) begin
         f_eff = FAC_W'(MAX_FACTOR);
      end else begin
         f_eff = FAC_W'(factor_ff);
      end
      if (width_ff == '0) begin
         w_eff = WID_W'(1);
      end else if (32'(width_ff) > WIDTH_LIMIT) begin
         w_eff = WID_W'(WIDTH_LIMIT);
      end else begin
         w_eff = WID_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HGT_W'(1);
      end else if (32'(height_ff) > HEIGHT_LIMIT) begin
         h_eff = HGT_W'(HEIGHT_LIMIT);
      end else begin
         h_eff = HGT_W'(height_ff);
      end
   end

   assign advance = !(rsp_valid_ff && !rsp_ch.ready && div_valid);
   assign req_ch.ready = advance && !csr_ch.valid;
   assign csr_ch.ready = 1'b1;
   assign req_acc = req_ch.valid && req_ch.ready;
   assign csr_acc = csr_ch.valid && csr_ch.ready;
   assign csr_hit = csr_ch.index == CSR_BLOCK_FACTOR || csr_ch.index == CSR_IN_WIDTH ||
                    csr_ch.index == CSR_IN_HEIGHT;

   assign col_ok   = EXT_W'(col_blk_ff) + EXT_W'(f_eff) <= EXT_W'(w_eff);
   assign row_ok   = RX_W'(row_blk_ff) + RX_W'(f_eff) <= RX_W'(h_eff);
   assign in_blk   = col_ok && row_ok;
   assign c_wrap   = FAC_W'(cphase_ff) + FAC_W'(1) >= f_eff;
   assign r_wrap   = FAC_W'(rphase_ff) + FAC_W'(1) >= f_eff;
   assign col_last = EXT_W'(col_ff) + EXT_W'(1) >= EXT_W'(w_eff);
   assign row_last = RX_W'(row_ff) + RX_W'(1) >= RX_W'(h_eff);
   assign mark_now.row_done =
      EXT_W'(col_ff) + EXT_W'(1) + EXT_W'(f_eff) > EXT_W'(w_eff);
   assign mark_now.frame_done = mark_now.row_done &&
      (RX_W'(row_ff) + RX_W'(1) + RX_W'(f_eff) > RX_W'(h_eff));
   assign sum_now = (cphase_ff == '0) ? RS_W'(req_ch.pixel_value)
                                      : row_sum_ff + RS_W'(req_ch.pixel_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff  <= FACTOR_W'(1);
         width_ff   <= SIZE_W'(4096);
         height_ff  <= SIZE_W'(4096);
         col_ff     <= '0;
         col_blk_ff <= '0;
         oc_ff      <= '0;
         row_ff     <= '0;
         row_blk_ff <= '0;
         cphase_ff  <= '0;
         rphase_ff  <= '0;
         row_sum_ff <= '0;
      end else if (csr_acc) begin
         case (csr_ch.index)
            CSR_BLOCK_FACTOR: factor_ff <= csr_ch.data[FACTOR_W-1:0];
            CSR_IN_WIDTH:     width_ff  <= csr_ch.data;
            CSR_IN_HEIGHT:    height_ff <= csr_ch.data;
            default: ;
         endcase
         if (csr_hit) begin
            col_ff     <= '0;
            col_blk_ff <= '0;
            oc_ff      <= '0;
            row_ff     <= '0;
            row_blk_ff <= '0;
            cphase_ff  <= '0;
            rphase_ff  <= '0;
            row_sum_ff <= '0;
         end
      end else if (req_acc) begin
         if (in_blk) begin
            row_sum_ff <= sum_now;
         end
         if (col_last) begin
            col_ff     <= '0;
            col_blk_ff <= '0;
            oc_ff      <= '0;
            cphase_ff  <= '0;
            if (row_last) begin
               row_ff     <= '0;
               row_blk_ff <= '0;
               rphase_ff  <= '0;
            end else begin
               row_ff <= row_ff + ROW_W'(1);
               if (r_wrap) begin
                  rphase_ff  <= '0;
                  row_blk_ff <= row_ff + ROW_W'(1);
               end else begin
                  rphase_ff <= rphase_ff + PH_W'(1);
               end
            end
         end else begin
            col_ff <= col_ff + COL_W'(1);
            if (c_wrap) begin
               cphase_ff  <= '0;
               col_blk_ff <= col_ff + COL_W'(1);
               oc_ff      <= oc_ff + COL_W'(1);
            end else begin
               cphase_ff <= cphase_ff + PH_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_acc && in_blk && c_wrap;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_first_ff <= rphase_ff == '0;
         s1_last_ff  <= r_wrap;
         s1_sum_ff   <= sum_now;
         s1_addr_ff  <= oc_ff;
         s1_mark_ff  <= mark_now;
      end
      recip_ff   <= recip_tbl[f_eff];
      divisor_ff <= DIV_W'(f_eff) * DIV_W'(f_eff);
   end

   assign s1_total = s1_first_ff ? TOT_W'(s1_sum_ff) : mem_rd_ff + TOT_W'(s1_sum_ff);
   assign mem_we   = s1_valid_ff && !s1_last_ff && advance;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         col_mem[s1_addr_ff] <= s1_total;
      end
      if (req_acc) begin
         mem_rd_ff <= col_mem[oc_ff];
      end
   end

   boxds_divide #(
      .TOT_W (TOT_W),
      .RCP_W (RCP_W),
      .DIV_W (DIV_W)
   ) u_divide (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s1_valid_ff && s1_last_ff),
      .in_total  (s1_total),
      .in_mark   (s1_mark_ff),
      .recip     (recip_ff),
      .divisor   (divisor_ff),
      .out_valid (div_valid),
      .out_rsp   (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && div_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && div_valid) begin
         rsp_data_ff <= div_rsp;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.average_value = rsp_data_ff.average_value;
   assign rsp_ch.row_done      = rsp_data_ff.row_done;
   assign rsp_ch.frame_done    = rsp_data_ff.frame_done;

   `BOXDS_ASSERT(a_no_mem_hazard, clock, reset,
      mem_we |-> !(req_acc && in_blk && c_wrap && rphase_ff != '0 && oc_ff == s1_addr_ff),
      "column sum read in the cycle of its own write back")
   `BOXDS_ASSERT(a_phase_bound, clock, reset,
      FAC_W'(cphase_ff) < f_eff && FAC_W'(rphase_ff) < f_eff,
      "block phase reached the block factor")
   `BOXDS_ASSERT_ALWAYS(a_frame_implies_row, clock,
      rsp_ch.valid && rsp_ch.frame_done |-> rsp_ch.row_done,
      "frame end marked without row end")

endmodule
